// ===== design/sst_pkg.sv =====
// Shared types, constants and microcode program of the sine-squared series engine.
package sst_pkg;

   localparam int MAX_TERMS  = 16;
   localparam int X_W        = 32;
   localparam int SUM_W      = 64;
   localparam int STOP_W     = 5;
   localparam int THR_W      = 41;
   localparam int TLIM_W     = 5;
   localparam int MAG_W      = 63;
   localparam int RC_W       = 48;
   localparam int ACC_W      = 128;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 41;
   localparam int STEP_W     = 5;

   localparam logic [CSR_ADDR_W-1:0] REG_STOP_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TERM_LIMIT     = 1'd1;

   localparam logic [THR_W-1:0]  THR_RESET  = 41'd1;
   localparam logic [TLIM_W-1:0] TLIM_RESET = 5'd16;

   localparam logic [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;
   localparam logic [ACC_W-1:0] RND46   = 128'd1 << 45;
   localparam logic [ACC_W-1:0] RND58   = 128'd1 << 57;

   // Multiplier operand selects.
   localparam logic [2:0] A_X      = 3'd0;
   localparam logic [2:0] A_SQ_LO  = 3'd1;
   localparam logic [2:0] A_SQ_HI  = 3'd2;
   localparam logic [2:0] A_MAG_LO = 3'd3;
   localparam logic [2:0] A_MAG_HI = 3'd4;

   localparam logic [2:0] B_X      = 3'd0;
   localparam logic [2:0] B_RC_LO  = 3'd1;
   localparam logic [2:0] B_RC_HI  = 3'd2;
   localparam logic [2:0] B_FAC_LO = 3'd3;
   localparam logic [2:0] B_FAC_HI = 3'd4;

   // Accumulator operations and partial-product alignment.
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_32 = 2'd1;
   localparam logic [1:0] SH_64 = 2'd2;

   // Register write-back selects.
   localparam logic [2:0] WB_NONE = 3'd0;
   localparam logic [2:0] WB_SQ   = 3'd1;
   localparam logic [2:0] WB_MAG0 = 3'd2;
   localparam logic [2:0] WB_FAC  = 3'd3;
   localparam logic [2:0] WB_MAG  = 3'd4;

   // Branch kinds.
   localparam logic [2:0] BR_NEXT = 3'd0;
   localparam logic [2:0] BR_WAIT = 3'd1;
   localparam logic [2:0] BR_TERM = 3'd2;
   localparam logic [2:0] BR_JUMP = 3'd3;
   localparam logic [2:0] BR_OUT  = 3'd4;

   // Program addresses.
   localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
   localparam logic [STEP_W-1:0] ST_LOOP = 5'd4;
   localparam logic [STEP_W-1:0] ST_OUT  = 5'd17;

   typedef struct packed {
      logic [2:0]        a_sel;
      logic [2:0]        b_sel;
      logic              mul_en;
      logic [1:0]        acc_op;
      logic [1:0]        acc_sh;
      logic [2:0]        wb;
      logic [2:0]        br;
      logic [STEP_W-1:0] tgt;
   } ctl_type;

   typedef struct packed {
      logic below_thr;
      logic at_limit;
   } stat_type;

   function automatic ctl_type cw(input logic [2:0] a_sel, input logic [2:0] b_sel,
                                  input logic mul_en, input logic [1:0] acc_op,
                                  input logic [1:0] acc_sh, input logic [2:0] wb,
                                  input logic [2:0] br, input logic [STEP_W-1:0] tgt);
      ctl_type w;
      w.a_sel  = a_sel;
      w.b_sel  = b_sel;
      w.mul_en = mul_en;
      w.acc_op = acc_op;
      w.acc_sh = acc_sh;
      w.wb     = wb;
      w.br     = br;
      w.tgt    = tgt;
      return w;
   endfunction

   // Control store: one word per step.
   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type w;
      unique case (step)
         5'd0:  w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_NONE, BR_WAIT, ST_IDLE);
         5'd1:  w = cw(A_X, B_X, 1'b1, ACC_NONE, SH_0, WB_NONE, BR_NEXT, ST_IDLE);
         5'd2:  w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_SQ, BR_NEXT, ST_IDLE);
         5'd3:  w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_MAG0, BR_NEXT, ST_IDLE);
         5'd4:  w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_NONE, BR_TERM, ST_OUT);
         5'd5:  w = cw(A_SQ_LO, B_RC_LO, 1'b1, ACC_NONE, SH_0, WB_NONE, BR_NEXT, ST_IDLE);
         5'd6:  w = cw(A_SQ_LO, B_RC_HI, 1'b1, ACC_LOAD, SH_0, WB_NONE, BR_NEXT, ST_IDLE);
         5'd7:  w = cw(A_SQ_HI, B_RC_LO, 1'b1, ACC_ADD, SH_32, WB_NONE, BR_NEXT, ST_IDLE);
         5'd8:  w = cw(A_SQ_HI, B_RC_HI, 1'b1, ACC_ADD, SH_32, WB_NONE, BR_NEXT, ST_IDLE);
         5'd9:  w = cw(A_X, B_X, 1'b0, ACC_ADD, SH_64, WB_NONE, BR_NEXT, ST_IDLE);
         5'd10: w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_FAC, BR_NEXT, ST_IDLE);
         5'd11: w = cw(A_MAG_LO, B_FAC_LO, 1'b1, ACC_NONE, SH_0, WB_NONE, BR_NEXT, ST_IDLE);
         5'd12: w = cw(A_MAG_LO, B_FAC_HI, 1'b1, ACC_LOAD, SH_0, WB_NONE, BR_NEXT, ST_IDLE);
         5'd13: w = cw(A_MAG_HI, B_FAC_LO, 1'b1, ACC_ADD, SH_32, WB_NONE, BR_NEXT, ST_IDLE);
         5'd14: w = cw(A_MAG_HI, B_FAC_HI, 1'b1, ACC_ADD, SH_32, WB_NONE, BR_NEXT, ST_IDLE);
         5'd15: w = cw(A_X, B_X, 1'b0, ACC_ADD, SH_64, WB_NONE, BR_NEXT, ST_IDLE);
         5'd16: w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_MAG, BR_JUMP, ST_LOOP);
         5'd17: w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_NONE, BR_OUT, ST_IDLE);
         default: w = cw(A_X, B_X, 1'b0, ACC_NONE, SH_0, WB_NONE, BR_JUMP, ST_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ===== design/sine_squared_taylor_series.sv =====
// Top level of the sine-squared Taylor series engine.
// Usage: an argument x (signed Q2.29) is transferred on the req_ channel; one
// result (sum of series terms in signed Q23.40 plus stop index and flags) comes
// back on the rsp_ channel. The csr_ port writes the stop threshold (index 0)
// and the term limit (index 1); write them only while no item is in flight.
// One item is worked on at a time by a microcoded sequence around a single
// 32x32 multiplier. Each later term takes thirteen steps: a threshold check,
// four partial products for the factor and four for the term update, each added
// into a 128-bit accumulator, plus rounding write-backs. The next input is
// taken only once the result has been registered in the output register, so
// a new item cannot start before the last one is through the whole series.
// The result sits in an output register; the input side accepts the next item
// while it waits, and a finished item stalls only if the previous result has
// still not been taken. Reset returns the sequencer to idle, drops rsp_tvalid
// and restores the threshold to 1 and the term limit to 16.
module sine_squared_taylor_series #(
   parameter int MAX_TERMS = sst_pkg::MAX_TERMS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sst_pkg::REQ_DATA_W-1:0]    req_tdata,   // [31:0] arg_x
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] series_sum, [68:64] stop_index, [69] limit_reached, [70] saturated
   output logic [sst_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [sst_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sst_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   sst_pkg::ctl_type  ctl;
   sst_pkg::stat_type stat;

   logic [sst_pkg::THR_W-1:0]      thr_ff;
   logic [sst_pkg::TLIM_W-1:0]     tlim_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sst_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                           req_fire;
   logic                           out_free;
   logic                           load_rsp;
   logic [sst_pkg::SUM_W-1:0]      series_sum;
   logic [sst_pkg::STOP_W-1:0]     stop_index;
   logic                           limit_reached;
   logic                           saturated;

   assign req_tready = (ctl.br == sst_pkg::BR_WAIT);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_rsp   = (ctl.br == sst_pkg::BR_OUT) && out_free;

   sst_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .stat     (stat),
      .ctl      (ctl)
   );

   sst_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock          (clock),
      .ctl            (ctl),
      .req_fire       (req_fire),
      .arg_x          (req_tdata[sst_pkg::X_W-1:0]),
      .stop_threshold (thr_ff),
      .term_limit     (tlim_ff),
      .stat           (stat),
      .series_sum     (series_sum),
      .stop_index     (stop_index),
      .limit_reached  (limit_reached),
      .saturated      (saturated)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= sst_pkg::THR_RESET;
         tlim_ff <= sst_pkg::TLIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            sst_pkg::REG_STOP_THRESHOLD: thr_ff  <= csr_wr_data[sst_pkg::THR_W-1:0];
            sst_pkg::REG_TERM_LIMIT:     tlim_ff <= csr_wr_data[sst_pkg::TLIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, saturated, limit_reached, stop_index, series_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/sst_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
module sst_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               out_free,
   input  sst_pkg::stat_type  stat,
   output sst_pkg::ctl_type   ctl
);

   logic [sst_pkg::STEP_W-1:0] step_ff;
   logic [sst_pkg::STEP_W-1:0] step_in;

   assign ctl = sst_pkg::ucode(step_ff);

   always_comb begin
      step_in = step_ff + sst_pkg::STEP_W'(1);
      unique case (ctl.br)
         sst_pkg::BR_NEXT: begin
         end
         sst_pkg::BR_WAIT: begin
            if (!req_fire) step_in = step_ff;
         end
         sst_pkg::BR_TERM: begin
            if (stat.below_thr || stat.at_limit) step_in = ctl.tgt;
         end
         sst_pkg::BR_JUMP: begin
            step_in = ctl.tgt;
         end
         sst_pkg::BR_OUT: begin
            step_in = out_free ? ctl.tgt : step_ff;
         end
         default: begin
            step_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= sst_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== design/sst_dp.sv =====
// Datapath: shared 32x32 multiplier, 128-bit accumulator, term and sum registers.
module sst_dp #(
   parameter int MAX_TERMS = sst_pkg::MAX_TERMS
) (
   input  logic                          clock,
   input  sst_pkg::ctl_type              ctl,
   input  logic                          req_fire,
   input  logic [sst_pkg::X_W-1:0]       arg_x,
   input  logic [sst_pkg::THR_W-1:0]     stop_threshold,
   input  logic [sst_pkg::TLIM_W-1:0]    term_limit,
   output sst_pkg::stat_type             stat,
   output logic [sst_pkg::SUM_W-1:0]     series_sum,
   output logic [sst_pkg::STOP_W-1:0]    stop_index,
   output logic                          limit_reached,
   output logic                          saturated
);

   localparam int IW = $clog2(MAX_TERMS + 2);
   localparam int TW = $clog2(MAX_TERMS);

   logic [sst_pkg::X_W-1:0]    x_ff, x_in;
   logic [sst_pkg::MAG_W-1:0]  sq_ff, sq_in;
   logic [sst_pkg::MAG_W-1:0]  mag_ff, mag_in;
   logic [sst_pkg::MAG_W-1:0]  fac_ff, fac_in;
   logic [63:0]                pp_ff, pp_in;
   logic [sst_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [sst_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [IW-1:0]              stop_ff, stop_in;
   logic                       neg_ff, neg_in;
   logic                       sat_ff, sat_in;
   logic                       byl_ff, byl_in;

   logic [sst_pkg::RC_W-1:0]   rc_tab [MAX_TERMS];
   logic [sst_pkg::RC_W-1:0]   rc;
   logic [31:0]                mul_a, mul_b;
   logic [sst_pkg::ACC_W-1:0]  pp_sh;
   logic [sst_pkg::ACC_W-1:0]  rnd;
   logic [IW-1:0]              lim;
   logic                       start;
   logic [sst_pkg::SUM_W:0]    sx, ext, snew;
   logic                       sovf;

   // Reciprocals 1/((2i+1)(2i+2)) in Q0.48, rounded.
   for (genvar g = 0; g < MAX_TERMS; g++) begin : g_rc
      localparam longint unsigned D  = (2 * g + 1) * (2 * g + 2);
      localparam logic [47:0]     RV = 48'(((64'd1 << 48) + D / 2) / D);
      assign rc_tab[g] = RV;
   end

   assign rc    = rc_tab[idx_ff[TW-1:0]];
   assign start = (ctl.br == sst_pkg::BR_WAIT) && req_fire;

   always_comb begin
      if (term_limit == '0) begin
         lim = IW'(1);
      end else if (32'(term_limit) > MAX_TERMS) begin
         lim = IW'(MAX_TERMS);
      end else begin
         lim = IW'(term_limit);
      end
   end

   assign stat.below_thr = mag_ff <= {{(sst_pkg::MAG_W - sst_pkg::THR_W){1'b0}}, stop_threshold};
   assign stat.at_limit  = idx_ff == lim;

   always_comb begin
      unique case (ctl.a_sel)
         sst_pkg::A_X:      mul_a = x_ff;
         sst_pkg::A_SQ_LO:  mul_a = sq_ff[31:0];
         sst_pkg::A_SQ_HI:  mul_a = {1'b0, sq_ff[62:32]};
         sst_pkg::A_MAG_LO: mul_a = mag_ff[31:0];
         sst_pkg::A_MAG_HI: mul_a = {1'b0, mag_ff[62:32]};
         default:           mul_a = '0;
      endcase
      unique case (ctl.b_sel)
         sst_pkg::B_X:      mul_b = x_ff;
         sst_pkg::B_RC_LO:  mul_b = rc[31:0];
         sst_pkg::B_RC_HI:  mul_b = {16'b0, rc[47:32]};
         sst_pkg::B_FAC_LO: mul_b = fac_ff[31:0];
         sst_pkg::B_FAC_HI: mul_b = {1'b0, fac_ff[62:32]};
         default:           mul_b = '0;
      endcase
      unique case (ctl.acc_sh)
         sst_pkg::SH_0:  pp_sh = {64'b0, pp_ff};
         sst_pkg::SH_32: pp_sh = {32'b0, pp_ff, 32'b0};
         sst_pkg::SH_64: pp_sh = {pp_ff, 64'b0};
         default:        pp_sh = '0;
      endcase
   end

   assign rnd = acc_ff + ((ctl.wb == sst_pkg::WB_FAC) ? sst_pkg::RND46 : sst_pkg::RND58);

   assign sx   = {sum_ff[sst_pkg::SUM_W-1], sum_ff};
   assign ext  = {2'b00, mag_ff};
   assign snew = neg_ff ? (sx - ext) : (sx + ext);
   assign sovf = snew[sst_pkg::SUM_W] ^ snew[sst_pkg::SUM_W-1];

   always_comb begin
      x_in    = x_ff;
      sq_in   = sq_ff;
      mag_in  = mag_ff;
      fac_in  = fac_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      sum_in  = sum_ff;
      idx_in  = idx_ff;
      stop_in = stop_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      byl_in  = byl_ff;

      if (start) begin
         x_in   = arg_x[sst_pkg::X_W-1] ? (~arg_x + sst_pkg::X_W'(1)) : arg_x;
         idx_in = IW'(1);
         sum_in = '0;
         neg_in = 1'b0;
         sat_in = 1'b0;
      end

      if (ctl.mul_en) pp_in = {32'b0, mul_a} * {32'b0, mul_b};

      unique case (ctl.acc_op)
         sst_pkg::ACC_NONE: begin
         end
         sst_pkg::ACC_LOAD: acc_in = pp_sh;
         sst_pkg::ACC_ADD:  acc_in = acc_ff + pp_sh;
         default: begin
         end
      endcase

      unique case (ctl.wb)
         sst_pkg::WB_NONE: begin
         end
         sst_pkg::WB_SQ: begin
            sq_in = pp_ff[62:0];
         end
         sst_pkg::WB_MAG0: begin
            mag_in = sst_pkg::MAG_W'(({1'b0, sq_ff} + 64'd131072) >> 18);
         end
         sst_pkg::WB_FAC: begin
            if (|rnd[127:109]) begin
               fac_in = '1;
               sat_in = 1'b1;
            end else begin
               fac_in = rnd[108:46];
            end
         end
         sst_pkg::WB_MAG: begin
            if (|rnd[127:121]) begin
               mag_in = '1;
               sat_in = 1'b1;
            end else begin
               mag_in = rnd[120:58];
            end
            idx_in = idx_ff + IW'(1);
            neg_in = !neg_ff;
         end
         default: begin
         end
      endcase

      if (ctl.br == sst_pkg::BR_TERM) begin
         if (stat.below_thr) begin
            stop_in = idx_ff;
            byl_in  = 1'b0;
         end else begin
            if (sovf) begin
               sum_in = snew[sst_pkg::SUM_W] ? sst_pkg::SUM_MIN : sst_pkg::SUM_MAX;
               sat_in = 1'b1;
            end else begin
               sum_in = snew[sst_pkg::SUM_W-1:0];
            end
            if (stat.at_limit) begin
               stop_in = idx_ff + IW'(1);
               byl_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      sq_ff   <= sq_in;
      mag_ff  <= mag_in;
      fac_ff  <= fac_in;
      pp_ff   <= pp_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
      idx_ff  <= idx_in;
      stop_ff <= stop_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      byl_ff  <= byl_in;
   end

   assign series_sum    = sum_ff;
   assign stop_index    = sst_pkg::STOP_W'(stop_ff);
   assign limit_reached = byl_ff;
   assign saturated     = sat_ff;

endmodule
